FILE: design/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types and constants for the duplicate-free index stack.
// ----------------------------------------------------------------------------
`default_nettype none

package dis_pkg;

	localparam int ITEMS = 256;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	typedef enum logic [1:0] {
		ST_PUSHED    = 2'd0,
		ST_DUP       = 2'd1,
		ST_POPPED    = 2'd2,
		ST_EMPTY_POP = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic {
		IDLE = 1'b0,
		EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: design/dis_ctrl.sv
// ----------------------------------------------------------------------------
// dis_ctrl
// Controller: takes a transaction, then runs its execute state.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_ctrl
	import dis_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output ctrl_cmd_t       cmd,
	output logic            busy
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b0;
		case (state_q)
			IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = EXEC;
				end
			end
			EXEC: begin
				busy       = 1'b1;
				cmd.exec   = 1'b1;
				state_next = IDLE;
			end
			default: begin
				state_next = IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/dis_dpath.sv
// ----------------------------------------------------------------------------
// dis_dpath
// Datapath: stack memory, presence bitmap, depth counter and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_dpath
	import dis_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctrl_cmd_t        cmd,
	input  wire logic             func,
	input  wire logic [IDX_W-1:0] item_index,
	output logic                  done,
	output logic [IDX_W-1:0]      popped_index,
	output logic [1:0]            status,
	output logic                  is_empty,
	output logic [CNT_W-1:0]      depth
);

	logic [IDX_W-1:0] mem [ITEMS];
	logic [ITEMS-1:0] presence_q;
	logic [CNT_W-1:0] count_q;
	func_t            func_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] top_q;

	logic             done_q;
	logic [IDX_W-1:0] popped_q;
	status_t          status_q;
	logic             empty_q;
	logic [CNT_W-1:0] depth_q;

	logic             push_ok;
	logic             pop_ok;
	logic [CNT_W-1:0] count_next;
	logic [CNT_W-1:0] count_dec;

	assign count_dec = count_q - CNT_W'(1);
	assign push_ok   = cmd.exec && (func_q == FUNC_PUSH) && !presence_q[idx_q]
		&& (count_q != CNT_W'(ITEMS));
	assign pop_ok    = cmd.exec && (func_q == FUNC_POP) && (count_q != '0);

	always_comb begin
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (pop_ok) begin
			count_next = count_dec;
		end
	end

	// top entry is read while the transaction is taken
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[count_q[IDX_W-1:0]] <= idx_q;
		end
		if (cmd.load) begin
			top_q <= mem[count_dec[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(func);
			idx_q  <= item_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presence_q <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			if (push_ok) begin
				presence_q[idx_q] <= 1'b1;
			end else if (pop_ok) begin
				presence_q[top_q] <= 1'b0;
			end
			count_q <= count_next;
			done_q  <= cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			popped_q <= pop_ok ? top_q : '0;
			empty_q  <= (count_next == '0);
			depth_q  <= count_next;
			if (func_q == FUNC_PUSH) begin
				status_q <= push_ok ? ST_PUSHED : ST_DUP;
			end else begin
				status_q <= pop_ok ? ST_POPPED : ST_EMPTY_POP;
			end
		end
	end

	assign done         = done_q;
	assign popped_index = popped_q;
	assign status       = status_q;
	assign is_empty     = empty_q;
	assign depth        = depth_q;

endmodule

`default_nettype wire

FILE: design/dedup_index_stack.sv
// ----------------------------------------------------------------------------
// dedup_index_stack
// Stack of 8-bit indices that never holds the same index twice.
// ----------------------------------------------------------------------------
// channel   handshake        payload
// command   start / busy     func, item_index
// result    done (strobe)    popped_index, status, is_empty, depth
//
// a transaction has two steps: the accept cycle reads the top entry from the
// stack memory, the execute cycle updates memory, bitmap and depth
// the result shows for one cycle after the execute cycle; a new start is
// taken in that same cycle, but not during the execute cycle while busy is high
// reset clears the presence bitmap and depth counter at once, no clearing pass
// the result cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_index_stack
	import dis_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             func,
	input  wire logic [IDX_W-1:0] item_index,
	output logic                  done,
	output logic [IDX_W-1:0]      popped_index,
	output logic [1:0]            status,
	output logic                  is_empty,
	output logic [CNT_W-1:0]      depth
);

	ctrl_cmd_t cmd;

	dis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy)
	);

	dis_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.item_index   (item_index),
		.done         (done),
		.popped_index (popped_index),
		.status       (status),
		.is_empty     (is_empty),
		.depth        (depth)
	);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not enter execute");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an execute cycle");

	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (depth == '0)))
		else $error("empty flag disagrees with depth");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY_POP)) |-> (is_empty && (popped_index == '0)))
		else $error("failed pop reported on a non-empty stack");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the duplicate-free index stack. A driver sends
// push and pop transactions with random gaps, and a monitor predicts each
// result from its own stack and presence map and checks every strobed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import dis_pkg::*;

	typedef struct {
		bit              drain;
		int              gap;
		func_t           op;
		logic [IDX_W-1:0] idx;
	} access_t;

	typedef struct {
		logic [IDX_W-1:0] popped;
		status_t          st;
		logic             empty;
		logic [CNT_W-1:0] depth;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             func = FUNC_PUSH;
	logic [IDX_W-1:0] item_index = '0;
	logic             busy;
	logic             done;
	logic [IDX_W-1:0] popped_index;
	logic [1:0]       status;
	logic             is_empty;
	logic [CNT_W-1:0] depth;

	access_t     access_q[$];
	outcome_t    outcome_q[$];
	int unsigned issued_cnt = 0;
	int unsigned answered_cnt = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned n_items = 0;
	bit          burst = 1'b0;

	// predicted block state
	logic [IDX_W-1:0] stack_mem [ITEMS];
	bit               present [ITEMS];
	int unsigned      stack_depth = 0;

	dedup_index_stack i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.item_index   (item_index),
		.done         (done),
		.popped_index (popped_index),
		.status       (status),
		.is_empty     (is_empty),
		.depth        (depth)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic flag_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_cnt++;
	endtask

	function automatic outcome_t apply_access(func_t op, logic [IDX_W-1:0] idx);
		outcome_t res;
		res.popped = '0;
		if (op == FUNC_PUSH) begin
			if (idx >= ITEMS || present[idx] || stack_depth >= ITEMS) begin
				res.st = ST_DUP;
			end else begin
				stack_mem[stack_depth] = idx;
				stack_depth++;
				present[idx] = 1'b1;
				res.st = ST_PUSHED;
			end
		end else if (stack_depth == 0) begin
			res.st = ST_EMPTY_POP;
		end else begin
			stack_depth--;
			res.popped = stack_mem[stack_depth];
			present[res.popped] = 1'b0;
			res.st = ST_POPPED;
		end
		res.empty = (stack_depth == 0);
		res.depth = stack_depth[CNT_W-1:0];
		return res;
	endfunction

	task automatic add_access(func_t op, int idx);
		access_t a;
		a.drain = 1'b0;
		a.op = op;
		a.idx = idx[IDX_W-1:0];
		a.gap = burst ? 0 : $urandom_range(0, 18);
		access_q.push_back(a);
		n_items++;
	endtask

	// sender holds off here until every outstanding result is back
	task automatic add_drain();
		access_t a;
		a.drain = 1'b1;
		a.op = FUNC_PUSH;
		a.idx = '0;
		a.gap = 0;
		access_q.push_back(a);
	endtask

	always @(posedge clk) begin : drive
		int unsigned sent_now;
		access_t     nxt;
		sent_now = issued_cnt + ((start && !busy) ? 1 : 0);
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			issued_cnt <= sent_now;
			if (!(start && busy)) begin
				if (access_q.size() == 0) begin
					start <= 1'b0;
				end else if (access_q[0].gap > 0) begin
					access_q[0].gap = access_q[0].gap - 1;
					start <= 1'b0;
				end else if (access_q[0].drain) begin
					start <= 1'b0;
					if (sent_now == answered_cnt)
						void'(access_q.pop_front());
				end else begin
					nxt = access_q.pop_front();
					start <= 1'b1;
					func <= nxt.op;
					item_index <= nxt.idx;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				answered_cnt <= answered_cnt + 1;
				if (outcome_q.size() == 0) begin
					flag_mismatch("result with no transaction pending");
				end else begin
					want = outcome_q.pop_front();
					if (popped_index !== want.popped)
						flag_mismatch($sformatf("popped_index %0d, want %0d",
							popped_index, want.popped));
					if (status !== want.st)
						flag_mismatch($sformatf("status %0d, want %s", status, want.st.name()));
					if (is_empty !== want.empty)
						flag_mismatch($sformatf("is_empty %b, want %b", is_empty, want.empty));
					if (depth !== want.depth)
						flag_mismatch($sformatf("depth %0d, want %0d", depth, want.depth));
				end
			end
			if (start && !busy)
				outcome_q.push_back(apply_access(func_t'(func), item_index));
		end
	end

	initial begin : stimulus
		int  perm [ITEMS];
		int  j;
		int  tmp;
		int  kind;
		int  len;
		int  push_pct;
		int  base;
		bit  narrow;
		bit  did_fill;
		did_fill = 1'b0;

		// directed: empty pop, index extremes, duplicates, alternating bits
		add_access(FUNC_POP, 0);
		add_access(FUNC_PUSH, 0);
		add_access(FUNC_PUSH, 255);
		add_access(FUNC_PUSH, 0);
		add_access(FUNC_PUSH, 255);
		add_access(FUNC_PUSH, 170);
		add_access(FUNC_PUSH, 85);
		add_access(FUNC_POP, 255);
		add_access(FUNC_POP, 0);
		add_access(FUNC_PUSH, 170);
		add_access(FUNC_POP, 170);
		add_access(FUNC_POP, 85);
		add_access(FUNC_POP, 0);
		add_access(FUNC_POP, 255);
		add_access(FUNC_PUSH, 1);
		add_access(FUNC_POP, 0);
		add_drain();

		while (n_items < 1750) begin
			burst = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			// a full fill adds over 500 transactions, so only start one early enough
			if ((kind == 0 && n_items < 1200) || (!did_fill && n_items > 600)) begin
				// push every index shuffled, then overfill and pop past empty
				did_fill = 1'b1;
				for (int i = 0; i < ITEMS; i++)
					perm[i] = i;
				for (int i = ITEMS - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				for (int i = 0; i < ITEMS; i++)
					add_access(FUNC_PUSH, perm[i]);
				for (int i = 0; i < 3; i++)
					add_access(FUNC_PUSH, $urandom_range(0, 255));
				for (int i = 0; i < ITEMS + 3; i++)
					add_access(FUNC_POP, $urandom_range(0, 255));
			end else begin
				len = $urandom_range(20, 120);
				push_pct = $urandom_range(30, 75);
				narrow = $urandom_range(0, 1);
				base = $urandom_range(0, 255);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < push_pct) begin
						// a narrow index window makes duplicates frequent
						if (narrow)
							add_access(FUNC_PUSH, (base + $urandom_range(0, 7)) % 256);
						else
							add_access(FUNC_PUSH, $urandom_range(0, 255));
					end else begin
						add_access(FUNC_POP, $urandom_range(0, 255));
					end
				end
			end
			if ($urandom_range(0, 4) == 0)
				add_drain();
		end

		do
			@(negedge clk);
		while (access_q.size() != 0 || start || issued_cnt != answered_cnt);
		repeat (4) @(posedge clk);
		if (outcome_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", outcome_q.size()));

		if (mismatch_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
